// ===== src/nfrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrd_pkg
// Shared sizes, command codes and link types for the 4bpp rectangle drawer.
// ----------------------------------------------------------------------------
package nfrd_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;

    function automatic int f_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;

    localparam int ADDR_W = f_bits(STORE_BYTES);
    localparam int COL_W  = f_bits(SCREEN_WIDTH);
    localparam int BCOL_W = f_bits(ROW_BYTES);
    localparam int ROW_W  = f_bits(SCREEN_HEIGHT);

    // payload widths
    localparam int FUNC_W  = 3;
    localparam int COORD_W = 16;
    localparam int GRAY_W  = 4;
    localparam int IDX_W   = 13;
    localparam int BYTE_W  = 8;

    // last on-screen column / row, signed for compares against coordinates
    localparam logic signed [COORD_W:0] X_MAX = (COORD_W + 1)'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W:0] Y_MAX = (COORD_W + 1)'(SCREEN_HEIGHT - 1);

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_FILL    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_OUTLINE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BOX     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] x_first;
        logic signed [COORD_W-1:0] y_first;
        logic signed [COORD_W-1:0] x_second;
        logic signed [COORD_W-1:0] y_second;
        logic [GRAY_W-1:0]         gray_level;
        logic [IDX_W-1:0]          byte_index;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              was_read;
    } t_result;

    // request to the two nibble planes
    typedef struct packed {
        logic              we_hi;
        logic              we_lo;
        logic [ADDR_W-1:0] waddr;
        logic [GRAY_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== src/nfrd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrd_if
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface nfrd_cmd_if;
    logic                                        valid;
    logic                                        ready;
    logic [nfrd_pkg::FUNC_W-1:0]                 func;
    logic signed [nfrd_pkg::COORD_W-1:0]         x_first;
    logic signed [nfrd_pkg::COORD_W-1:0]         y_first;
    logic signed [nfrd_pkg::COORD_W-1:0]         x_second;
    logic signed [nfrd_pkg::COORD_W-1:0]         y_second;
    logic [nfrd_pkg::GRAY_W-1:0]                 gray_level;
    logic [nfrd_pkg::IDX_W-1:0]                  byte_index;

    modport source (
        output valid, func, x_first, y_first, x_second, y_second, gray_level, byte_index,
        input  ready
    );
    modport sink (
        input  valid, func, x_first, y_first, x_second, y_second, gray_level, byte_index,
        output ready
    );
endinterface

interface nfrd_res_if;
    logic                        valid;
    logic                        ready;
    logic [nfrd_pkg::BYTE_W-1:0] read_byte;
    logic                        was_read;

    modport source (output valid, read_byte, was_read, input ready);
    modport sink   (input valid, read_byte, was_read, output ready);
endinterface

// ===== src/nfrd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nfrd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrd_seq
// Command sequencer: corner sort, clipping, row/byte walk over one address
// adder that drives the nibble planes.
// ----------------------------------------------------------------------------
module nfrd_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  nfrd_pkg::t_cmd     i_cmd,
    output nfrd_pkg::t_mem_req o_mem,
    input  logic [nfrd_pkg::BYTE_W-1:0] i_rdata,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output nfrd_pkg::t_result  o_res
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SORT    = 11'b000_0000_0010,
        S_PREP    = 11'b000_0000_0100,
        S_BASE    = 11'b000_0000_1000,
        S_ROW     = 11'b000_0001_0000,
        S_SPAN    = 11'b000_0010_0000,
        S_EDGE_LO = 11'b000_0100_0000,
        S_EDGE_HI = 11'b000_1000_0000,
        S_FILL    = 11'b001_0000_0000,
        S_RWAIT   = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    logic [nfrd_pkg::FUNC_W-1:0]          r_func;
    logic signed [nfrd_pkg::COORD_W-1:0]  r_xa, r_ya, r_xb, r_yb;
    logic [nfrd_pkg::GRAY_W-1:0]          r_gray;
    logic [nfrd_pkg::IDX_W-1:0]           r_idx;
    logic                                 r_solid;
    logic [nfrd_pkg::COL_W-1:0]           r_left, r_right;
    logic                                 r_lo_ok, r_hi_ok, r_top_on, r_bot_on;
    logic [nfrd_pkg::ROW_W-1:0]           r_row, r_row_end, r_top_row, r_bot_row;
    logic [nfrd_pkg::BCOL_W-1:0]          r_col;
    logic [nfrd_pkg::ADDR_W-1:0]          r_base;
    logic [nfrd_pkg::BYTE_W-1:0]          r_rdata;

    logic [nfrd_pkg::BCOL_W-1:0] left_b, right_b, col_sel;
    logic [nfrd_pkg::ADDR_W-1:0] addr;
    logic idx_ok, span_row, last_row;
    logic x_lo_neg, x_lo_over, x_hi_neg, x_hi_over;
    logic y_lo_neg, y_lo_over, y_hi_neg, y_hi_over;

    assign left_b   = nfrd_pkg::BCOL_W'(r_left >> 1);
    assign right_b  = nfrd_pkg::BCOL_W'(r_right >> 1);
    assign idx_ok   = (32'(r_idx) < 32'(nfrd_pkg::STORE_BYTES));
    assign span_row = r_solid || (r_top_on && (r_row == r_top_row))
                              || (r_bot_on && (r_row == r_bot_row));
    assign last_row = (r_row == r_row_end);

    // clip tests on the sorted corners (lo in r_xa/r_ya, hi in r_xb/r_yb)
    assign x_lo_neg  = (r_xa < 0);
    assign x_lo_over = (r_xa > nfrd_pkg::X_MAX);
    assign x_hi_neg  = (r_xb < 0);
    assign x_hi_over = (r_xb > nfrd_pkg::X_MAX);
    assign y_lo_neg  = (r_ya < 0);
    assign y_lo_over = (r_ya > nfrd_pkg::Y_MAX);
    assign y_hi_neg  = (r_yb < 0);
    assign y_hi_over = (r_yb > nfrd_pkg::Y_MAX);

    // shared address adder: row base plus byte column
    always_comb begin
        case (r_state)
            S_SPAN:    col_sel = r_col;
            S_EDGE_LO: col_sel = left_b;
            S_EDGE_HI: col_sel = right_b;
            default:   col_sel = '0;
        endcase
        addr = r_base + nfrd_pkg::ADDR_W'(col_sel);
    end

    always_comb begin
        o_mem.waddr = addr;
        o_mem.wdata = r_gray;
        o_mem.re    = (r_state == S_SORT) && (r_func == nfrd_pkg::FUNC_READ) && idx_ok;
        o_mem.raddr = nfrd_pkg::ADDR_W'(r_idx);
        case (r_state)
            S_FILL: begin
                o_mem.we_hi = 1'b1;
                o_mem.we_lo = 1'b1;
            end
            S_SPAN: begin
                // partial nibble only at the clipped ends of a span
                o_mem.we_hi = !((r_col == left_b) && r_left[0]);
                o_mem.we_lo = !((r_col == right_b) && !r_right[0]);
            end
            S_EDGE_LO: begin
                o_mem.we_hi = r_lo_ok && !r_left[0];
                o_mem.we_lo = r_lo_ok && r_left[0];
            end
            S_EDGE_HI: begin
                o_mem.we_hi = r_hi_ok && !r_right[0];
                o_mem.we_lo = r_hi_ok && r_right[0];
            end
            default: begin
                o_mem.we_hi = 1'b0;
                o_mem.we_lo = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_func  <= i_cmd.func;
                        r_xa    <= i_cmd.x_first;
                        r_ya    <= i_cmd.y_first;
                        r_xb    <= i_cmd.x_second;
                        r_yb    <= i_cmd.y_second;
                        r_gray  <= i_cmd.gray_level;
                        r_idx   <= i_cmd.byte_index;
                        r_rdata <= '0;
                        r_state <= S_SORT;
                    end
                end
                S_SORT: begin
                    r_solid <= (r_func == nfrd_pkg::FUNC_BOX);
                    if (r_func == nfrd_pkg::FUNC_PIXEL) begin
                        // a pixel is a one-by-one outline
                        r_xb <= r_xa;
                        r_yb <= r_ya;
                    end else begin
                        if (r_xa > r_xb) begin
                            r_xa <= r_xb;
                            r_xb <= r_xa;
                        end
                        if (r_ya > r_yb) begin
                            r_ya <= r_yb;
                            r_yb <= r_ya;
                        end
                    end
                    case (r_func)
                        nfrd_pkg::FUNC_FILL: begin
                            r_base  <= '0;
                            r_state <= S_FILL;
                        end
                        nfrd_pkg::FUNC_PIXEL,
                        nfrd_pkg::FUNC_OUTLINE,
                        nfrd_pkg::FUNC_BOX:  r_state <= S_PREP;
                        nfrd_pkg::FUNC_READ: r_state <= S_RWAIT;
                        default:             r_state <= S_DONE;
                    endcase
                end
                S_PREP: begin
                    r_left    <= x_lo_neg  ? '0 : nfrd_pkg::COL_W'(r_xa);
                    r_right   <= x_hi_over ? nfrd_pkg::COL_W'(nfrd_pkg::SCREEN_WIDTH - 1)
                                           : nfrd_pkg::COL_W'(r_xb);
                    r_lo_ok   <= !x_lo_neg && !x_lo_over;
                    r_hi_ok   <= !x_hi_neg && !x_hi_over;
                    r_row     <= y_lo_neg  ? '0 : nfrd_pkg::ROW_W'(r_ya);
                    r_row_end <= y_hi_over ? nfrd_pkg::ROW_W'(nfrd_pkg::SCREEN_HEIGHT - 1)
                                           : nfrd_pkg::ROW_W'(r_yb);
                    r_top_on  <= !y_lo_neg && !y_lo_over;
                    r_bot_on  <= !y_hi_neg && !y_hi_over;
                    r_top_row <= nfrd_pkg::ROW_W'(r_ya);
                    r_bot_row <= nfrd_pkg::ROW_W'(r_yb);
                    if (!x_hi_neg && !x_lo_over && !y_hi_neg && !y_lo_over) begin
                        r_state <= S_BASE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_BASE: begin
                    r_base  <= nfrd_pkg::ADDR_W'(32'(r_row) * nfrd_pkg::ROW_BYTES);
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (span_row) begin
                        r_col   <= left_b;
                        r_state <= S_SPAN;
                    end else begin
                        r_state <= S_EDGE_LO;
                    end
                end
                S_SPAN: begin
                    if (r_col == right_b) begin
                        if (last_row) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_base  <= r_base + nfrd_pkg::ADDR_W'(nfrd_pkg::ROW_BYTES);
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_EDGE_LO: begin
                    r_state <= S_EDGE_HI;
                end
                S_EDGE_HI: begin
                    if (last_row) begin
                        r_state <= S_DONE;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_base  <= r_base + nfrd_pkg::ADDR_W'(nfrd_pkg::ROW_BYTES);
                        r_state <= S_ROW;
                    end
                end
                S_FILL: begin
                    if (r_base == nfrd_pkg::ADDR_W'(nfrd_pkg::STORE_BYTES - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_base <= r_base + 1'b1;
                    end
                end
                S_RWAIT: begin
                    r_rdata <= idx_ok ? i_rdata : '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready     = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.read_byte = r_rdata;
    assign o_res.was_read  = (r_func == nfrd_pkg::FUNC_READ);

endmodule

// ===== src/nibble_framebuffer_rect_drawer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_framebuffer_rect_drawer_top
// 4bpp framebuffer with fill, pixel, rectangle outline, filled box and read.
// ----------------------------------------------------------------------------
// One command per transaction on i_cmd, one result transaction on o_res for
// every command. The block works on one command at a time; i_cmd.ready is
// low while a command is in progress. All drawing goes through a single
// byte-address adder and one shared write address, so bytes are written one
// at a time: fill walks every byte of the store; a filled box walks each
// byte of the clipped span on every clipped row; an outline walks the span
// bytes of the top and bottom rows and the two side pixels on each row
// in between; a pixel runs as a one-by-one outline; a read fetches one byte.
// Clipped-away commands and unused codes finish without writing. The picture
// is held as two nibble planes (even column high, odd column low) so partial
// byte writes need no read-modify-write. Memory contents are undefined after
// reset: issue a fill before drawing or reading. A finished result sits in
// an output register, so the next command can be taken while it waits.
// ----------------------------------------------------------------------------
module nibble_framebuffer_rect_drawer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nfrd_cmd_if.sink      i_cmd,
    nfrd_res_if.source    o_res
);

    nfrd_pkg::t_cmd     cmd;
    nfrd_pkg::t_mem_req mem;
    nfrd_pkg::t_result  seq_res;
    logic               seq_res_valid;
    logic               seq_res_ready;
    logic [nfrd_pkg::GRAY_W-1:0] rdata_hi, rdata_lo;

    // output register
    logic              r_out_valid;
    nfrd_pkg::t_result r_out;

    // pack the command transaction
    assign cmd.func       = i_cmd.func;
    assign cmd.x_first    = i_cmd.x_first;
    assign cmd.y_first    = i_cmd.y_first;
    assign cmd.x_second   = i_cmd.x_second;
    assign cmd.y_second   = i_cmd.y_second;
    assign cmd.gray_level = i_cmd.gray_level;
    assign cmd.byte_index = i_cmd.byte_index;

    nfrd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .i_cmd       (cmd),
        .o_mem       (mem),
        .i_rdata     ({rdata_hi, rdata_lo}),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res)
    );

    // even-column plane (high nibble of each byte)
    nfrd_ram #(
        .WIDTH (nfrd_pkg::GRAY_W),
        .DEPTH (nfrd_pkg::STORE_BYTES)
    ) u_plane_hi (
        .i_clk   (i_clk),
        .i_we    (mem.we_hi),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata_hi)
    );

    // odd-column plane (low nibble)
    nfrd_ram #(
        .WIDTH (nfrd_pkg::GRAY_W),
        .DEPTH (nfrd_pkg::STORE_BYTES)
    ) u_plane_lo (
        .i_clk   (i_clk),
        .i_we    (mem.we_lo),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata_lo)
    );

    // result slot is free when empty or being drained this cycle
    assign seq_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid && seq_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.read_byte = r_out.read_byte;
    assign o_res.was_read  = r_out.was_read;

endmodule

// ===== src/nfrd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfrd_checker
// Port-level checks on the rectangle drawer, bound to the top level.
// ----------------------------------------------------------------------------
module nfrd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [nfrd_pkg::BYTE_W-1:0] i_res_read_byte,
    input logic                        i_res_was_read
);

    // commands taken but not yet answered
    logic [1:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({i_cmd_valid && i_cmd_ready, i_res_valid && i_res_ready})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before transaction");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while previous one still in progress");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_pending != 2'd0)
        else $error("result with no command outstanding");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 |-> !i_cmd_ready)
        else $error("ready with result slot and sequencer both occupied");

    a_zero_nonread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_was_read |-> i_res_read_byte == '0)
        else $error("non-read result carries data");

endmodule

bind nibble_framebuffer_rect_drawer_top nfrd_checker u_nfrd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_read_byte (o_res.read_byte),
    .i_res_was_read  (o_res.was_read)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4bpp framebuffer rectangle drawer.
// ----------------------------------------------------------------------------
// Commands go in from a queue through a valid/ready driver, and results are
// taken by a receiver that stalls at random. Every accepted command is run
// through a local copy of the framebuffer. That copy predicts the one result
// that the command must return, and the monitor checks each result against
// the oldest prediction. The first command is always a fill, so no byte is
// ever read or partly drawn before it holds a defined value.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT   = 40000;  // about 5x the slowest command (full box)
    localparam int MAX_GAP      = 18;
    localparam int RANDOM_ITEMS = 75;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    // codes that the block must accept and answer without doing anything
    localparam logic [nfrd_pkg::FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [nfrd_pkg::FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

    typedef struct {
        nfrd_pkg::t_cmd cmd;
        bit             drain;  // hold this command back until every result is in
    } t_stim;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nfrd_cmd_if cmd_if ();
    nfrd_res_if res_if ();

    nibble_framebuffer_rect_drawer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Framebuffer model: two pixels per byte, even column in the high nibble
    // ------------------------------------------------------------------------
    logic [nfrd_pkg::BYTE_W-1:0] frame_bytes [nfrd_pkg::STORE_BYTES];
    t_stim                       pending_cmds [$];
    nfrd_pkg::t_result           expected_replies [$];
    int                          fail_cnt = 0;

    function automatic void plot_pixel(input int x, input int y, input logic [3:0] gray);
        int idx;
        // off-screen pixels are dropped
        if (x < 0 || x >= nfrd_pkg::SCREEN_WIDTH || y < 0 || y >= nfrd_pkg::SCREEN_HEIGHT)
            return;
        idx = y * nfrd_pkg::ROW_BYTES + x / 2;
        if (x % 2 == 0)
            frame_bytes[idx][7:4] = gray;
        else
            frame_bytes[idx][3:0] = gray;
    endfunction

    // left <= right already; clipped to the screen columns
    function automatic void draw_span(input int left, input int right, input int y,
                                      input logic [3:0] gray);
        if (y < 0 || y >= nfrd_pkg::SCREEN_HEIGHT)
            return;
        if (left < 0)
            left = 0;
        if (right > nfrd_pkg::SCREEN_WIDTH - 1)
            right = nfrd_pkg::SCREEN_WIDTH - 1;
        for (int x = left; x <= right; x++)
            plot_pixel(x, y, gray);
    endfunction

    function automatic void paint_rect(input int x1, input int y1, input int x2, input int y2,
                                       input logic [3:0] gray, input bit solid);
        int t;
        int lo;
        int hi;
        if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
        end
        if (y1 > y2) begin
            t = y1; y1 = y2; y2 = t;
        end
        if (solid) begin
            lo = (y1 < 0) ? 0 : y1;
            hi = (y2 > nfrd_pkg::SCREEN_HEIGHT - 1) ? nfrd_pkg::SCREEN_HEIGHT - 1 : y2;
            for (int y = lo; y <= hi; y++)
                draw_span(x1, x2, y, gray);
        end else begin
            draw_span(x1, x2, y1, gray);
            draw_span(x1, x2, y2, gray);
            // side edges only on the rows strictly between top and bottom
            lo = (y1 + 1 < 0) ? 0 : y1 + 1;
            hi = (y2 - 1 > nfrd_pkg::SCREEN_HEIGHT - 1) ? nfrd_pkg::SCREEN_HEIGHT - 1 : y2 - 1;
            for (int y = lo; y <= hi; y++) begin
                plot_pixel(x1, y, gray);
                plot_pixel(x2, y, gray);
            end
        end
    endfunction

    // updates the framebuffer copy and returns the result the command owes
    function automatic nfrd_pkg::t_result apply_command(input nfrd_pkg::t_cmd c);
        nfrd_pkg::t_result r;
        int                xa;
        int                ya;
        int                xb;
        int                yb;
        r  = '0;
        xa = $signed(c.x_first);
        ya = $signed(c.y_first);
        xb = $signed(c.x_second);
        yb = $signed(c.y_second);
        case (c.func)
            nfrd_pkg::FUNC_FILL: begin
                for (int i = 0; i < nfrd_pkg::STORE_BYTES; i++)
                    frame_bytes[i] = {c.gray_level, c.gray_level};
            end
            nfrd_pkg::FUNC_PIXEL:   plot_pixel(xa, ya, c.gray_level);
            nfrd_pkg::FUNC_OUTLINE: paint_rect(xa, ya, xb, yb, c.gray_level, 1'b0);
            nfrd_pkg::FUNC_BOX:     paint_rect(xa, ya, xb, yb, c.gray_level, 1'b1);
            nfrd_pkg::FUNC_READ: begin
                r.was_read = 1'b1;
                // reads past the store return zero
                if (int'(c.byte_index) < nfrd_pkg::STORE_BYTES)
                    r.read_byte = frame_bytes[c.byte_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cmd(input logic [nfrd_pkg::FUNC_W-1:0] func, input int x1,
                            input int y1, input int x2, input int y2, input int gray,
                            input int idx, input bit drain);
        t_stim s;
        s.cmd.func       = func;
        s.cmd.x_first    = 16'(x1);
        s.cmd.y_first    = 16'(y1);
        s.cmd.x_second   = 16'(x2);
        s.cmd.y_second   = 16'(y2);
        s.cmd.gray_level = 4'(gray);
        s.cmd.byte_index = 13'(idx);
        s.drain          = drain;
        pending_cmds.push_back(s);
    endtask

    function automatic int any_coord();
        return int'($signed(16'($urandom())));
    endfunction

    // mostly on screen, some near the borders, a few anywhere in 16 bits
    function automatic int pick_coord(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return any_coord();
        if (r <= 3)
            return int'($urandom_range(0, span + 23)) - 12;
        return int'($urandom_range(0, span - 1));
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int byte_addr(input int x, input int y);
        return y * nfrd_pkg::ROW_BYTES + x / 2;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: changes inputs on the falling edge
    // ------------------------------------------------------------------------
    logic cmd_took = 1'b0;  // command transaction at the last rising edge
    logic res_took = 1'b0;  // result transaction at the last rising edge
    int   send_gap = 0;
    bit   send_calm = 1'b0;
    int   recv_wait = 0;
    bit   recv_calm = 1'b0;

    initial begin
        cmd_if.valid      = 1'b0;
        cmd_if.func       = nfrd_pkg::FUNC_FILL;
        cmd_if.x_first    = '0;
        cmd_if.y_first    = '0;
        cmd_if.x_second   = '0;
        cmd_if.y_second   = '0;
        cmd_if.gray_level = '0;
        cmd_if.byte_index = '0;
        res_if.ready      = 1'b0;
    end

    always @(negedge i_clk) begin
        logic  nxt_valid;
        t_stim s;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            nxt_valid = cmd_if.valid;
            if (cmd_if.valid && cmd_took) begin
                nxt_valid = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() != 0 &&
                             !(pending_cmds[0].drain && expected_replies.size() != 0)) begin
                    s = pending_cmds.pop_front();
                    cmd_if.func       <= s.cmd.func;
                    cmd_if.x_first    <= s.cmd.x_first;
                    cmd_if.y_first    <= s.cmd.y_first;
                    cmd_if.x_second   <= s.cmd.x_second;
                    cmd_if.y_second   <= s.cmd.y_second;
                    cmd_if.gray_level <= s.cmd.gray_level;
                    cmd_if.byte_index <= s.cmd.byte_index;
                    nxt_valid = 1'b1;
                end
            end
            // single update of valid per edge, so back-to-back stays high
            cmd_if.valid <= nxt_valid;
        end
    end

    // result receiver: after each result, stalls at random before taking the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_took) begin
                if ($urandom_range(0, 15) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples on the rising edge, checks results, then predicts
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        nfrd_pkg::t_cmd    taken;
        nfrd_pkg::t_result want;
        if (!i_rst_n) begin
            cmd_took <= 1'b0;
            res_took <= 1'b0;
        end else begin
            cmd_took <= cmd_if.valid && cmd_if.ready;
            res_took <= res_if.valid && res_if.ready;
            // results first: a result can never belong to a command taken at this edge
            if (res_if.valid && res_if.ready) begin
                if (expected_replies.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: read_byte %h was_read %b",
                                 $time, res_if.read_byte, res_if.was_read);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("read_byte", res_if.read_byte, want.read_byte);
                    check_field("was_read", 8'(res_if.was_read), 8'(want.was_read));
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                taken.func       = cmd_if.func;
                taken.x_first    = cmd_if.x_first;
                taken.y_first    = cmd_if.y_first;
                taken.x_second   = cmd_if.x_second;
                taken.y_second   = cmd_if.y_second;
                taken.gray_level = cmd_if.gray_level;
                taken.byte_index = cmd_if.byte_index;
                expected_replies.push_back(apply_command(taken));
            end
        end
    end

    // watchdog: any transaction on either side counts as progress
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int rnd_items;
        int r;
        int gray;
        int x1;
        int y1;
        int x2;
        int y2;
        int px;
        int py;
        int nreads;
        logic [nfrd_pkg::FUNC_W-1:0] func;

        // directed part; the store is undefined until the first fill
        push_cmd(nfrd_pkg::FUNC_FILL, 0, 0, 0, 0, 4'hA, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_PIXEL, 0, 0, 0, 0, 4'hF, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_PIXEL, 127, 127, 0, 0, 4'h0, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_PIXEL, -1, 5, 0, 0, 4'h3, 0, 1'b0);           // off the left
        push_cmd(nfrd_pkg::FUNC_PIXEL, 128, 127, 0, 0, 4'h3, 0, 1'b0);        // off the right
        push_cmd(nfrd_pkg::FUNC_PIXEL, 32767, -32768, 0, 0, 4'h3, 0, 1'b0);   // far off
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, nfrd_pkg::STORE_BYTES - 1, 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(0, 5), 1'b0);
        // outline given with both corners reversed
        push_cmd(nfrd_pkg::FUNC_OUTLINE, 10, 20, 3, 5, 4'h3, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(3, 5), 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(10, 12), 1'b0);
        // box hanging off the top-left corner, sent after the pipe drains
        push_cmd(nfrd_pkg::FUNC_BOX, -5, -5, 4, 2, 4'hC, 0, 1'b1);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(4, 2), 1'b0);
        // span clipped on the right
        push_cmd(nfrd_pkg::FUNC_BOX, 140, 60, 120, 70, 4'h6, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(127, 65), 1'b0);
        // outline around the whole coordinate space: nothing lands on screen
        push_cmd(nfrd_pkg::FUNC_OUTLINE, -32768, -32768, 32767, 32767, 4'h7, 0, 1'b0);
        // clipped spans, side edges both off screen
        push_cmd(nfrd_pkg::FUNC_OUTLINE, -10, 60, 140, 90, 4'h1, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(0, 75), 1'b0);
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
            push_cmd(3'(f), any_coord(), any_coord(), any_coord(), any_coord(),
                     $urandom_range(0, 15), $urandom_range(0, nfrd_pkg::STORE_BYTES - 1),
                     1'b0);
        push_cmd(nfrd_pkg::FUNC_BOX, -32768, -32768, 32767, 32767, 4'hF, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_FILL, 0, 0, 0, 0, 4'h0, 0, 1'b0);
        push_cmd(nfrd_pkg::FUNC_READ, 0, 0, 0, 0, 0, byte_addr(64, 64), 1'b0);

        // random part: mostly a draw followed by reads of the area it touched
        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            r    = $urandom_range(0, 99);
            gray = $urandom_range(0, 15);
            if (r < 3) begin
                push_cmd(nfrd_pkg::FUNC_FILL, any_coord(), any_coord(), any_coord(),
                         any_coord(), gray, $urandom_range(0, nfrd_pkg::STORE_BYTES - 1),
                         1'b0);
                rnd_items++;
            end else if (r < 8) begin
                push_cmd(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                         any_coord(), any_coord(), any_coord(), any_coord(),
                         gray, $urandom_range(0, nfrd_pkg::STORE_BYTES - 1), 1'b0);
                rnd_items++;
            end else if (r < 14) begin
                push_cmd(nfrd_pkg::FUNC_READ, any_coord(), any_coord(), any_coord(),
                         any_coord(), gray, $urandom_range(0, nfrd_pkg::STORE_BYTES - 1),
                         1'b0);
                rnd_items++;
            end else begin
                func = (r < 40) ? nfrd_pkg::FUNC_PIXEL :
                       (r < 70) ? nfrd_pkg::FUNC_OUTLINE : nfrd_pkg::FUNC_BOX;
                x1 = pick_coord(nfrd_pkg::SCREEN_WIDTH);
                y1 = pick_coord(nfrd_pkg::SCREEN_HEIGHT);
                if (func == nfrd_pkg::FUNC_PIXEL) begin
                    x2 = any_coord();
                    y2 = any_coord();
                end else if ($urandom_range(0, 11) == 0) begin
                    // the odd big rectangle; most stay small to keep the run short
                    x2 = pick_coord(nfrd_pkg::SCREEN_WIDTH);
                    y2 = pick_coord(nfrd_pkg::SCREEN_HEIGHT);
                end else begin
                    x2 = x1 + int'($urandom_range(0, 24)) - 12;
                    y2 = y1 + int'($urandom_range(0, 24)) - 12;
                end
                push_cmd(func, x1, y1, x2, y2, gray,
                         $urandom_range(0, nfrd_pkg::STORE_BYTES - 1),
                         ($urandom_range(0, 24) == 0));
                rnd_items++;
                if (func == nfrd_pkg::FUNC_PIXEL) begin
                    x2 = x1;
                    y2 = y1;
                end
                // read back inside the drawn bounds, pulled onto the screen
                nreads = $urandom_range(1, 3);
                for (int k = 0; k < nreads; k++) begin
                    px = $urandom_range(clamp(x1, 0, nfrd_pkg::SCREEN_WIDTH - 1),
                                        clamp(16'(x2) == x2 ? x2 : x1, 0,
                                              nfrd_pkg::SCREEN_WIDTH - 1));
                    py = $urandom_range(clamp(y1, 0, nfrd_pkg::SCREEN_HEIGHT - 1),
                                        clamp(16'(y2) == y2 ? y2 : y1, 0,
                                              nfrd_pkg::SCREEN_HEIGHT - 1));
                    push_cmd(nfrd_pkg::FUNC_READ, any_coord(), any_coord(), any_coord(),
                             any_coord(), $urandom_range(0, 15), byte_addr(px, py), 1'b0);
                    rnd_items++;
                end
            end
        end

        // reset: held low, then released on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_if.valid || expected_replies.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && expected_replies.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== nibble_framebuffer_rect_drawer_top.f =====
src/nfrd_pkg.sv
src/nfrd_if.sv
src/nfrd_ram.sv
src/nfrd_seq.sv
src/nibble_framebuffer_rect_drawer_top.sv
src/nfrd_checker.sv
verif/tb.sv
